### rtl/clne_pkg.sv
// Shared types and codes for the circular list engine.
// No dependencies; every other file of the block refers to this package.
package clne_pkg;

    // Widths of the request and response fields.
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;

    // Default sizing of the node store.
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Write strobes from the sequencer to the node store.
    typedef struct packed {
        logic val_en;
        logic nxt_en;
    } t_store_wr;

endpackage

### rtl/clne_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on clne_pkg for the field widths.
interface clne_req_if;
    logic                        valid;
    logic                        ready;
    logic [clne_pkg::REQ_W-1:0]   req_type;
    logic [clne_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface clne_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [clne_pkg::VALUE_W-1:0]  current_value;
    logic                         list_empty;
    logic [clne_pkg::STATUS_W-1:0] status;

    modport source (output valid, output current_value, output list_empty,
                    output status, input ready);
    modport sink   (input valid, input current_value, input list_empty,
                    input status, output ready);
endinterface

### rtl/clne_store.sv
// Node store: value and next-index memories, one write port each and a
// shared registered read port. Depends on clne_pkg for the write strobes.
module clne_store #(
    parameter int CAPACITY   = clne_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = clne_pkg::VALUE_BITS_DEF,
    localparam int IDX_W     = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  clne_pkg::t_store_wr   i_wr,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_val,
    input  logic [IDX_W-1:0]      i_wr_nxt,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [VALUE_BITS-1:0] o_rd_val,
    output logic [IDX_W-1:0]      o_rd_nxt
);

    logic [VALUE_BITS-1:0] r_val_mem [CAPACITY];
    logic [IDX_W-1:0]      r_nxt_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [IDX_W-1:0]      r_rd_nxt;

    always_ff @(posedge i_clk) begin
        if (i_wr.val_en) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        r_rd_val <= r_val_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.nxt_en) begin
            r_nxt_mem[i_wr_addr] <= i_wr_nxt;
        end
        r_rd_nxt <= r_nxt_mem[i_rd_addr];
    end

    assign o_rd_val = r_rd_val;
    assign o_rd_nxt = r_rd_nxt;

endmodule

### rtl/circular_list_engine.sv
// Circular list engine top level: request sequencer around the node store.
// Depends on clne_pkg, clne_if (channels) and clne_store.
//
// The engine keeps a bounded circular singly linked list and answers every
// request with one response (current value, empty flag, status). Requests are
// handled one at a time; the request channel is ready only while the sequencer
// is idle, though a finished response may still wait in the output register.
// Every step goes through the single read port of the node store, so an
// advance passes S_ADV1 and S_ADV2, an insert S_INS1, S_INS2 and S_INS3
// (S_INS3 skipped into an empty list, none on a full store), and a delete
// S_DFIRST, S_WALK once per node examined and S_DFREE on a match that
// leaves nodes; requests on an empty list and unknown codes go to S_DONE.
// Freed nodes are kept on a free list threaded through the next-index
// memory, and never-used slots are handed out from a high-water count, so
// no clearing pass is needed after reset.
module circular_list_engine #(
    parameter int CAPACITY   = clne_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = clne_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clne_req_if.sink   i_req,
    clne_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW    = clne_pkg::VALUE_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS1   = 4'd1;
    localparam logic [3:0] S_INS2   = 4'd2;
    localparam logic [3:0] S_INS3   = 4'd3;
    localparam logic [3:0] S_DFIRST = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_DFREE  = 4'd6;
    localparam logic [3:0] S_ADV1   = 4'd7;
    localparam logic [3:0] S_ADV2   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]                    r_state, n_state;
    logic [VALUE_BITS-1:0]         r_v, n_v;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_hw, n_hw;
    logic [IDX_W-1:0]              r_free_head, n_free_head;
    logic [IDX_W-1:0]              r_cur, n_cur;
    logic [VALUE_BITS-1:0]         r_cur_val, n_cur_val;
    logic [IDX_W-1:0]              r_prev, n_prev;
    logic [VALUE_BITS-1:0]         r_prev_val, n_prev_val;
    logic [IDX_W-1:0]              r_n, n_n;
    logic [IDX_W-1:0]              r_slot, n_slot;
    logic                          r_from_free, n_from_free;
    logic [IDX_W-1:0]              r_iter, n_iter;
    logic [clne_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_out_valid, n_out_valid;
    logic [VW-1:0]                 r_out_val, n_out_val;
    logic                          r_out_empty, n_out_empty;
    logic [clne_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    clne_pkg::t_store_wr   w_wr;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_val;
    logic [IDX_W-1:0]      w_wr_nxt;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [VALUE_BITS-1:0] w_rd_val;
    logic [IDX_W-1:0]      w_rd_nxt;
    logic [VW+VALUE_BITS-1:0] w_in_ext;
    logic [VALUE_BITS+VW-1:0] w_cur_ext;
    logic                  w_accept;

    clne_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_val  (w_wr_val),
        .i_wr_nxt  (w_wr_nxt),
        .i_rd_addr (w_rd_addr),
        .o_rd_val  (w_rd_val),
        .o_rd_nxt  (w_rd_nxt)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_in_ext    = {{VALUE_BITS{1'b0}}, i_req.value};
    assign w_cur_ext   = {{VW{1'b0}}, r_cur_val};

    always_comb begin
        n_state      = r_state;
        n_v          = r_v;
        n_count      = r_count;
        n_hw         = r_hw;
        n_free_head  = r_free_head;
        n_cur        = r_cur;
        n_cur_val    = r_cur_val;
        n_prev       = r_prev;
        n_prev_val   = r_prev_val;
        n_n          = r_n;
        n_slot       = r_slot;
        n_from_free  = r_from_free;
        n_iter       = r_iter;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_val    = r_out_val;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        w_wr         = '0;
        w_wr_addr    = r_slot;
        w_wr_val     = r_v;
        w_wr_nxt     = r_free_head;
        w_rd_addr    = r_cur;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_v      = w_in_ext[VALUE_BITS-1:0];
                    n_status = clne_pkg::ST_OK;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        clne_pkg::REQ_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = clne_pkg::ST_FULL;
                            end else begin
                                w_rd_addr   = r_free_head;
                                n_from_free = (r_hw != r_count);
                                n_state     = S_INS1;
                            end
                        end
                        clne_pkg::REQ_DELETE: begin
                            if (r_count == '0) begin
                                n_status = clne_pkg::ST_EMPTY;
                            end else begin
                                w_rd_addr  = r_cur;
                                n_prev     = r_cur;
                                n_prev_val = r_cur_val;
                                n_iter     = '0;
                                n_state    = S_DFIRST;
                            end
                        end
                        clne_pkg::REQ_ADVANCE: begin
                            if (r_count == '0) begin
                                n_status = clne_pkg::ST_EMPTY;
                            end else begin
                                w_rd_addr = r_cur;
                                n_state   = S_ADV1;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS1: begin
                // A recycled slot comes off the free list; otherwise take a fresh one.
                if (r_from_free) begin
                    n_slot      = r_free_head;
                    n_free_head = w_rd_nxt;
                end else begin
                    n_slot = r_hw[IDX_W-1:0];
                    n_hw   = r_hw + CNT_W'(1);
                end
                w_rd_addr = r_cur;
                n_state   = S_INS2;
            end
            S_INS2: begin
                w_wr.val_en = 1'b1;
                w_wr.nxt_en = 1'b1;
                w_wr_addr   = r_slot;
                w_wr_val    = r_v;
                if (r_count == '0) begin
                    w_wr_nxt  = r_slot;
                    n_cur     = r_slot;
                    n_cur_val = r_v;
                    n_count   = CNT_W'(1);
                    n_state   = S_DONE;
                end else begin
                    w_wr_nxt = w_rd_nxt;
                    n_count  = r_count + CNT_W'(1);
                    n_state  = S_INS3;
                end
            end
            S_INS3: begin
                w_wr.nxt_en = 1'b1;
                w_wr_addr   = r_cur;
                w_wr_nxt    = r_slot;
                n_state     = S_DONE;
            end
            S_DFIRST: begin
                w_rd_addr = w_rd_nxt;
                n_n       = w_rd_nxt;
                n_state   = S_WALK;
            end
            S_WALK: begin
                // The store output holds the value and successor of the node
                // under test; the predecessor is kept in r_prev.
                if (w_rd_val == r_v) begin
                    if (r_count == CNT_W'(1)) begin
                        w_wr.nxt_en = 1'b1;
                        w_wr_addr   = r_n;
                        w_wr_nxt    = r_free_head;
                        n_free_head = r_n;
                        n_count     = '0;
                        n_cur       = '0;
                        n_cur_val   = '0;
                        n_state     = S_DONE;
                    end else begin
                        w_wr.nxt_en = 1'b1;
                        w_wr_addr   = r_prev;
                        w_wr_nxt    = w_rd_nxt;
                        n_cur       = r_prev;
                        n_cur_val   = r_prev_val;
                        n_count     = r_count - CNT_W'(1);
                        n_state     = S_DFREE;
                    end
                end else if (CNT_W'(r_iter) == r_count - CNT_W'(1)) begin
                    n_status = clne_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_prev     = r_n;
                    n_prev_val = w_rd_val;
                    n_iter     = r_iter + IDX_W'(1);
                    w_rd_addr  = w_rd_nxt;
                    n_n        = w_rd_nxt;
                end
            end
            S_DFREE: begin
                w_wr.nxt_en = 1'b1;
                w_wr_addr   = r_n;
                w_wr_nxt    = r_free_head;
                n_free_head = r_n;
                n_state     = S_DONE;
            end
            S_ADV1: begin
                w_rd_addr = w_rd_nxt;
                n_cur     = w_rd_nxt;
                n_state   = S_ADV2;
            end
            S_ADV2: begin
                n_cur_val = w_rd_val;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_val    = (r_count == '0) ? '0 : w_cur_ext[VW-1:0];
                    n_out_empty  = (r_count == '0);
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hw        <= '0;
            r_free_head <= '0;
            r_cur       <= '0;
            r_cur_val   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hw        <= n_hw;
            r_free_head <= n_free_head;
            r_cur       <= n_cur;
            r_cur_val   <= n_cur_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v          <= n_v;
        r_prev       <= n_prev;
        r_prev_val   <= n_prev_val;
        r_n          <= n_n;
        r_slot       <= n_slot;
        r_from_free  <= n_from_free;
        r_iter       <= n_iter;
        r_status     <= n_status;
        r_out_val    <= n_out_val;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.current_value = r_out_val;
    assign o_rsp.list_empty    = r_out_empty;
    assign o_rsp.status        = r_out_status;

endmodule

### tb/circular_list_engine_tb.sv
// Self-checking testbench for circular_list_engine: directed corner cases, then
// random insert/delete/advance traffic checked against a value-ring predictor.
// Depends on clne_pkg and the clne_req_if / clne_rsp_if channel interfaces.
module circular_list_engine_tb;

    localparam logic [clne_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [clne_pkg::VALUE_W-1:0]  cur;
        logic                          empty;
        logic [clne_pkg::STATUS_W-1:0] status;
    } t_list_answer;

    logic i_clk;
    logic i_rst_n;

    clne_req_if req_ch ();
    clne_rsp_if rsp_ch ();

    circular_list_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Values in ring order; entry 0 is the node under the current pointer.
    logic [clne_pkg::VALUE_W-1:0] ring[$];
    t_list_answer                 pending_answers[$];
    int                           error_count = 0;
    bit                           quiet_tail = 0;
    int                           idle_cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_list_answer predict_answer(
        input logic [clne_pkg::REQ_W-1:0]   kind,
        input logic [clne_pkg::VALUE_W-1:0] val);
        t_list_answer ans;
        int           n;
        int           hit;
        int           pred;
        n = ring.size();
        hit = -1;
        ans.status = clne_pkg::ST_OK;
        case (kind)
            clne_pkg::REQ_INSERT: begin
                if (n >= clne_pkg::CAPACITY_DEF) begin
                    ans.status = clne_pkg::ST_FULL;
                end else if (n == 0) begin
                    ring.push_back(val);
                end else begin
                    ring.insert(1, val);
                end
            end
            clne_pkg::REQ_DELETE: begin
                if (n == 0) begin
                    ans.status = clne_pkg::ST_EMPTY;
                end else begin
                    // The search starts after current and ends on current itself.
                    for (int k = 1; k <= n && hit < 0; k++) begin
                        if (ring[k % n] == val) hit = k % n;
                    end
                    if (hit < 0) begin
                        ans.status = clne_pkg::ST_NOT_FOUND;
                    end else if (n == 1) begin
                        ring.delete();
                    end else begin
                        ring.delete(hit);
                        pred = (hit == 0) ? n - 2 : hit - 1;
                        repeat (pred) ring.push_back(ring.pop_front());
                    end
                end
            end
            clne_pkg::REQ_ADVANCE: begin
                if (n == 0) ans.status = clne_pkg::ST_EMPTY;
                else ring.push_back(ring.pop_front());
            end
            default: ;
        endcase
        ans.empty = (ring.size() == 0);
        ans.cur = ans.empty ? '0 : ring[0];
        return ans;
    endfunction

    task automatic send_request(input logic [clne_pkg::REQ_W-1:0] kind,
                                input logic [clne_pkg::VALUE_W-1:0] val);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_answers.push_back(predict_answer(kind, val));
    endtask

    function automatic logic [clne_pkg::VALUE_W-1:0] pick_value(
        input logic [clne_pkg::REQ_W-1:0] kind);
        int roll;
        roll = $urandom_range(0, 99);
        if (kind == clne_pkg::REQ_DELETE && ring.size() != 0 && roll < 75)
            return ring[$urandom_range(0, ring.size() - 1)];
        if (roll < 85) return clne_pkg::VALUE_W'($urandom_range(0, 16'hFFFF));
        if (roll < 95) return clne_pkg::VALUE_W'($urandom_range(0, 7));
        return (roll[0]) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic test_empty_list();
        send_request(clne_pkg::REQ_DELETE, 16'h0000);
        send_request(clne_pkg::REQ_ADVANCE, 16'hFFFF);
        send_request(REQ_UNUSED, 16'h5A5A);
        send_request(clne_pkg::REQ_INSERT, 16'h0000);
        send_request(clne_pkg::REQ_DELETE, 16'h0000);
    endtask

    task automatic test_single_node();
        send_request(clne_pkg::REQ_INSERT, 16'hFFFF);
        send_request(clne_pkg::REQ_ADVANCE, 16'h0000);
        send_request(clne_pkg::REQ_DELETE, 16'h1234);
        send_request(REQ_UNUSED, 16'hFFFF);
        send_request(clne_pkg::REQ_DELETE, 16'hFFFF);
    endtask

    task automatic test_ring_order();
        send_request(clne_pkg::REQ_INSERT, 16'h0001);
        send_request(clne_pkg::REQ_INSERT, 16'h0002);
        send_request(clne_pkg::REQ_INSERT, 16'h0003);
        send_request(clne_pkg::REQ_INSERT, 16'h0002);
        send_request(clne_pkg::REQ_ADVANCE, 16'h0000);
        send_request(clne_pkg::REQ_DELETE, 16'h0002);
        send_request(clne_pkg::REQ_DELETE, 16'h0001);
        send_request(clne_pkg::REQ_ADVANCE, 16'h0000);
        send_request(clne_pkg::REQ_DELETE, 16'h0003);
        send_request(clne_pkg::REQ_DELETE, 16'h0002);
        send_request(clne_pkg::REQ_DELETE, 16'h0002);
    endtask

    // Grow the list until the store overflows, then drain it by matching deletes.
    task automatic test_fill_and_drain(input int rounds);
        logic [clne_pkg::REQ_W-1:0] kind;
        for (int r = 0; r < rounds; r++) begin
            while (ring.size() < clne_pkg::CAPACITY_DEF) begin
                kind = ($urandom_range(0, 5) == 0) ? clne_pkg::REQ_ADVANCE
                                                   : clne_pkg::REQ_INSERT;
                send_request(kind, pick_value(kind));
            end
            repeat ($urandom_range(1, 3))
                send_request(clne_pkg::REQ_INSERT, pick_value(clne_pkg::REQ_INSERT));
            while (ring.size() != 0) begin
                kind = ($urandom_range(0, 5) == 0) ? clne_pkg::REQ_ADVANCE
                                                   : clne_pkg::REQ_DELETE;
                send_request(kind, (kind == clne_pkg::REQ_DELETE)
                                   ? ring[$urandom_range(0, ring.size() - 1)]
                                   : pick_value(kind));
            end
            send_request(clne_pkg::REQ_DELETE, pick_value(clne_pkg::REQ_DELETE));
        end
    endtask

    task automatic test_mixed_traffic(input int items, input int insert_pct,
                                      input int delete_pct);
        int                         roll;
        logic [clne_pkg::REQ_W-1:0] kind;
        for (int i = 0; i < items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) kind = clne_pkg::REQ_INSERT;
            else if (roll < insert_pct + delete_pct) kind = clne_pkg::REQ_DELETE;
            else if (roll < 97) kind = clne_pkg::REQ_ADVANCE;
            else kind = REQ_UNUSED;
            send_request(kind, pick_value(kind));
        end
    endtask

    // Response sink: random stall bursts until the quiet tail of the run.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected response cur=%h empty=%b status=%0d", $time,
                         rsp_ch.current_value, rsp_ch.list_empty, rsp_ch.status);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (rsp_ch.current_value !== want.cur) begin
                    $display("%0t: current_value expected %h actual %h", $time, want.cur,
                             rsp_ch.current_value);
                    error_count++;
                end
                if (rsp_ch.list_empty !== want.empty) begin
                    $display("%0t: list_empty expected %b actual %b", $time, want.empty,
                             rsp_ch.list_empty);
                    error_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without a transfer on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= clne_pkg::REQ_INSERT;
        req_ch.value    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_single_node();
        test_ring_order();
        test_fill_and_drain(4);
        test_mixed_traffic(200, 50, 25);
        test_mixed_traffic(200, 30, 45);
        test_mixed_traffic(200, 40, 30);
        quiet_tail = 1;
        test_mixed_traffic(150, 45, 30);

        @(posedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
